// ===== hw/rtl/brbf_pkg.sv =====
// Shared request codes, field widths and the stage record of the byte ring buffer.
package brbf_pkg;

   localparam int unsigned TYPE_W  = 3;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned LOG_W   = 4;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_READ  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_PEEK  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DROP  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd4;

   localparam logic [LOG_W-1:0] CAP_LOG2_RESET = 4'd10;

   // outcome of one request, carried alongside the memory read
   typedef struct packed {
      logic               accepted;
      logic               has_data;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_count;
      logic               is_empty;
      logic               is_full;
   } meta_type;

endpackage

// ===== hw/rtl/brbf_channels.sv =====
// Valid/ready channel interfaces for requests and responses.
interface brbf_req_if
   import brbf_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  req_type;
   logic [DATA_W-1:0]  write_data;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output req_type, output write_data, output count,
                   input ready);
   modport sink   (input valid, input req_type, input write_data, input count,
                   output ready);
endinterface

interface brbf_rsp_if
   import brbf_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [DATA_W-1:0]  read_data;
   logic [COUNT_W-1:0] used_count;
   logic [COUNT_W-1:0] free_count;
   logic               is_empty;
   logic               is_full;

   modport source (output valid, output accepted, output read_data, output used_count,
                   output free_count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input accepted, input read_data, input used_count,
                   input free_count, input is_empty, input is_full, output ready);
endinterface

// ===== hw/rtl/brbf_mem.sv =====
// Byte store: one write port, one read port, registered read data.
module brbf_mem
   import brbf_pkg::*;
#(
   parameter int unsigned AW = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int unsigned ENTRIES = 1 << AW;

   logic [DATA_W-1:0] store_ff [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      // hold read data unless a new read is issued
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/brbf_ctrl.sv =====
// Counters, capacity register and request decode of the byte ring buffer.
module brbf_ctrl
   import brbf_pkg::*;
#(
   parameter int unsigned MAXLOG = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LOG_W-1:0]   csr_wdata,
   input  logic               accept,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [COUNT_W-1:0] count,
   output logic               mem_wr_en,
   output logic [MAXLOG-1:0]  mem_wr_addr,
   output logic               mem_rd_en,
   output logic [MAXLOG-1:0]  mem_rd_addr,
   output meta_type           meta
);

   localparam int unsigned CW = MAXLOG + 1;
   localparam int unsigned MW = (CW > COUNT_W) ? CW : COUNT_W;

   function automatic logic [CW-1:0] cap_of(input logic [LOG_W-1:0] log2_val);
      logic [LOG_W-1:0] k;
      k = log2_val;
      if (k < 4'd1) begin
         k = 4'd1;
      end
      if (k > MAXLOG) begin
         k = LOG_W'(MAXLOG);
      end
      return CW'(1) << k;
   endfunction

   logic [CW-1:0] cap_ff, wr_cnt_ff, rd_cnt_ff;
   logic [CW-1:0] wr_cnt_in, rd_cnt_in;
   logic [CW-1:0] amask, used, used_after, free_after, cnt_tr, peek_ptr;
   logic [MW-1:0] used_ext, cnt_ext, used_after_ext, free_after_ext;
   logic          ok;

   always_comb begin
      amask      = cap_ff - CW'(1);
      used       = wr_cnt_ff - rd_cnt_ff;
      used_ext   = MW'(used);
      cnt_ext    = MW'(count);
      cnt_tr     = CW'(cnt_ext);
      peek_ptr   = rd_cnt_ff + cnt_tr;
      wr_cnt_in  = wr_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      ok         = 1'b0;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      mem_wr_addr = wr_cnt_ff[MAXLOG-1:0] & amask[MAXLOG-1:0];
      mem_rd_addr = rd_cnt_ff[MAXLOG-1:0] & amask[MAXLOG-1:0];
      case (req_type)
         REQ_WRITE: begin
            ok        = used < cap_ff;
            mem_wr_en = accept && ok;
            wr_cnt_in = wr_cnt_ff + CW'(1);
         end
         REQ_READ: begin
            ok        = used != '0;
            mem_rd_en = accept && ok;
            rd_cnt_in = rd_cnt_ff + CW'(1);
         end
         REQ_PEEK: begin
            ok          = cnt_ext < used_ext;
            mem_rd_en   = accept && ok;
            mem_rd_addr = peek_ptr[MAXLOG-1:0] & amask[MAXLOG-1:0];
         end
         REQ_DROP: begin
            ok        = cnt_ext <= used_ext;
            rd_cnt_in = rd_cnt_ff + cnt_tr;
         end
         REQ_CLEAR: begin
            ok        = 1'b1;
            wr_cnt_in = '0;
            rd_cnt_in = '0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      // a refused request leaves the counters alone
      if (!ok) begin
         wr_cnt_in = wr_cnt_ff;
         rd_cnt_in = rd_cnt_ff;
      end
      used_after     = wr_cnt_in - rd_cnt_in;
      free_after     = cap_ff - used_after;
      used_after_ext = MW'(used_after);
      free_after_ext = MW'(free_after);
      meta.accepted   = ok;
      meta.has_data   = ok && ((req_type == REQ_READ) || (req_type == REQ_PEEK));
      meta.used_count = used_after_ext[COUNT_W-1:0];
      meta.free_count = free_after_ext[COUNT_W-1:0];
      meta.is_empty   = used_after == '0;
      meta.is_full    = used_after == cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= cap_of(CAP_LOG2_RESET);
         wr_cnt_ff <= '0;
         rd_cnt_ff <= '0;
      end else if (csr_we) begin
         cap_ff    <= cap_of(csr_wdata);
         wr_cnt_ff <= '0;
         rd_cnt_ff <= '0;
      end else if (accept) begin
         wr_cnt_ff <= wr_cnt_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

endmodule

// ===== hw/rtl/byte_ring_buffer_fifo_core.sv =====
// Top level of the byte ring buffer FIFO: channels, read stage and response register.
//
//  channel | direction | handshake        | carries
//  --------+-----------+------------------+----------------------------------------------
//  req     | in        | valid/ready      | req_type, write_data, count
//  rsp     | out       | valid/ready      | accepted, read_data, used/free counts, flags
//  csr     | in        | csr_we, no stall | capacity_log2 in csr_wdata
//
// One item per clock is accepted unless a stalled response holds it; a response is
// held in the read stage while the store reads, then in the response register.
// Counters are updated at the accepting edge, so the next item sees them at once.
// Reset (synchronous) empties the queue and sets the capacity to 2^10, clamped to the
// largest power of two within DEPTH; the byte store is not cleared. A stalled response
// holds the read stage, which then holds req ready low until the response is taken.
module byte_ring_buffer_fifo_core
   import brbf_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LOG_W-1:0] csr_wdata,
   brbf_req_if.sink         req,
   brbf_rsp_if.source       rsp
);

   // largest power of two not above DEPTH, as a log2
   localparam int unsigned MAXLOG = $clog2(DEPTH + 1) - 1;

   logic               accept;
   logic               s1_adv;
   logic               s1_valid_ff;
   meta_type           s1_meta_ff;
   meta_type           meta;
   logic               mem_wr_en, mem_rd_en;
   logic [MAXLOG-1:0]  mem_wr_addr, mem_rd_addr;
   logic [DATA_W-1:0]  mem_rd_data;

   logic               rsp_valid_ff;
   logic               rsp_accepted_ff;
   logic [DATA_W-1:0]  rsp_read_data_ff;
   logic [COUNT_W-1:0] rsp_used_ff, rsp_free_ff;
   logic               rsp_empty_ff, rsp_full_ff;

   // advance the read stage when the response register is free or being emptied
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   brbf_ctrl #(
      .MAXLOG (MAXLOG)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .req_type    (req.req_type),
      .count       (req.count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .meta        (meta)
   );

   // writes and reads never target the same entry in one cycle: a read only
   // reaches bytes stored by earlier items, whose writes have already landed
   brbf_mem #(
      .AW (MAXLOG)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req.write_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // read stage: hold the outcome while the store's read data settles
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_meta_ff <= meta;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         rsp_accepted_ff  <= s1_meta_ff.accepted;
         // drop the store's data unless the item read or peeked successfully
         rsp_read_data_ff <= s1_meta_ff.has_data ? mem_rd_data : '0;
         rsp_used_ff      <= s1_meta_ff.used_count;
         rsp_free_ff      <= s1_meta_ff.free_count;
         rsp_empty_ff     <= s1_meta_ff.is_empty;
         rsp_full_ff      <= s1_meta_ff.is_full;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.accepted   = rsp_accepted_ff;
   assign rsp.read_data  = rsp_read_data_ff;
   assign rsp.used_count = rsp_used_ff;
   assign rsp.free_count = rsp_free_ff;
   assign rsp.is_empty   = rsp_empty_ff;
   assign rsp.is_full    = rsp_full_ff;

endmodule

// ===== tb/brbf_checker.sv =====
// Checker for the byte ring buffer: mirrors the queue state and compares every response.
module brbf_checker
   import brbf_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LOG_W-1:0] csr_wdata,
   brbf_req_if              req,
   brbf_rsp_if              rsp,
   output int unsigned      responses_due,
   output int unsigned      mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

   typedef struct packed {
      logic               accepted;
      logic [DATA_W-1:0]  read_data;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_count;
      logic               is_empty;
      logic               is_full;
   } ring_answer_type;

   // mirrored queue state
   logic [DATA_W-1:0]  byte_mem [0:STORE_DEPTH-1];
   logic [COUNT_W-1:0] wr_ctr;
   logic [COUNT_W-1:0] rd_ctr;
   logic [LOG_W-1:0]   cap_log2;

   ring_answer_type answers_due[$];
   int unsigned     error_tally = 0;

   assign mismatches = error_tally;

   // capacity in use: a log2 of zero acts as one, anything above the store is clamped
   function automatic int unsigned capacity_now();
      int unsigned k;
      k = (cap_log2 == '0) ? 1 : cap_log2;
      return ((1 << k) > STORE_DEPTH) ? STORE_DEPTH : (1 << k);
   endfunction

   function automatic ring_answer_type apply_request(input logic [TYPE_W-1:0]  kind,
                                                     input logic [DATA_W-1:0]  data,
                                                     input logic [COUNT_W-1:0] cnt);
      ring_answer_type    ans;
      int unsigned        cap;
      logic [COUNT_W-1:0] amask;
      logic [COUNT_W-1:0] fill;
      cap   = capacity_now();
      amask = COUNT_W'(cap - 1);
      fill  = wr_ctr - rd_ctr;
      ans   = '0;
      case (kind)
         REQ_WRITE: if (fill < cap) begin
            byte_mem[ADDR_W'(wr_ctr & amask)] = data;
            wr_ctr       = wr_ctr + 1'b1;
            ans.accepted = 1'b1;
         end
         REQ_READ: if (fill != '0) begin
            ans.read_data = byte_mem[ADDR_W'(rd_ctr & amask)];
            rd_ctr        = rd_ctr + 1'b1;
            ans.accepted  = 1'b1;
         end
         REQ_PEEK: if (cnt < fill) begin
            ans.read_data = byte_mem[ADDR_W'((rd_ctr + cnt) & amask)];
            ans.accepted  = 1'b1;
         end
         REQ_DROP: if (cnt <= fill) begin
            rd_ctr       = rd_ctr + cnt;
            ans.accepted = 1'b1;
         end
         REQ_CLEAR: begin
            wr_ctr       = '0;
            rd_ctr       = '0;
            ans.accepted = 1'b1;
         end
         default: ;
      endcase
      fill           = wr_ctr - rd_ctr;
      ans.used_count = fill;
      ans.free_count = COUNT_W'(cap - fill);
      ans.is_empty   = (fill == '0);
      ans.is_full    = (fill == cap);
      return ans;
   endfunction

   task automatic compare_field(input string field, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         error_tally++;
      end
   endtask

   always @(posedge clock) begin
      ring_answer_type want;
      if (reset) begin
         wr_ctr   = '0;
         rd_ctr   = '0;
         cap_log2 = CAP_LOG2_RESET;
         answers_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               $error("response item with no request outstanding");
               error_tally++;
            end else begin
               want = answers_due.pop_front();
               compare_field("accepted", COUNT_W'(want.accepted), COUNT_W'(rsp.accepted));
               compare_field("read_data", COUNT_W'(want.read_data),
                             COUNT_W'(rsp.read_data));
               compare_field("used_count", want.used_count, rsp.used_count);
               compare_field("free_count", want.free_count, rsp.free_count);
               compare_field("is_empty", COUNT_W'(want.is_empty), COUNT_W'(rsp.is_empty));
               compare_field("is_full", COUNT_W'(want.is_full), COUNT_W'(rsp.is_full));
            end
         end
         // a capacity write also empties the queue
         if (csr_we) begin
            cap_log2 = csr_wdata;
            wr_ctr   = '0;
            rd_ctr   = '0;
         end
         if (req.valid && req.ready)
            answers_due.push_back(apply_request(req.req_type, req.write_data, req.count));
      end
      responses_due <= answers_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the byte ring buffer testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
   import brbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STORE_DEPTH = 1024;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned NUM_PHASES  = 8;

   // request codes the block must refuse
   localparam logic [TYPE_W-1:0] REQ_SPARE_LO = REQ_CLEAR + 3'd1;
   localparam logic [TYPE_W-1:0] REQ_SPARE_HI = '1;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [LOG_W-1:0] csr_wdata;

   int unsigned responses_due;
   int unsigned mismatches;
   int unsigned cycle_count = 0;
   bit          gaps_on = 1'b1;

   // capacity setting, random item count and write share of each phase;
   // the log2 extremes 0 and 15 exercise the clamping, 15 also fills the whole store
   int unsigned phase_log2 [NUM_PHASES] = '{0, 1, 3, 5, 15, 2, 8, 10};
   int unsigned phase_len  [NUM_PHASES] = '{80, 80, 100, 120, 60, 80, 120, 60};
   int unsigned phase_wpct [NUM_PHASES] = '{50, 55, 60, 55, 40, 50, 65, 50};

   brbf_req_if req_ch ();
   brbf_rsp_if rsp_ch ();

   byte_ring_buffer_fifo_core #(
      .DEPTH(STORE_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req      (req_ch),
      .rsp      (rsp_ch)
   );

   brbf_checker #(
      .STORE_DEPTH(STORE_DEPTH)
   ) ring_check (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .responses_due(responses_due),
      .mismatches   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sender idle time after an item: mostly none, sometimes a few cycles,
   // now and then a long pause. Whole phases may run with no idling at all.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one item and hold it until the block takes it. Entered and left
   // on a rising edge; valid stays high into the next item when there is no gap.
   task automatic send_item(input logic [TYPE_W-1:0]  kind,
                            input logic [DATA_W-1:0]  data,
                            input logic [COUNT_W-1:0] cnt);
      int unsigned gap;
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.write_data <= data;
      req_ch.count      <= cnt;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every response has been taken. The first edge
   // lets the checker register the item accepted in the current step.
   task automatic wait_all_answered();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (responses_due != 0) @(posedge clock);
   endtask

   // Write the capacity register; only called with the block idle.
   task automatic write_capacity(input logic [LOG_W-1:0] log2);
      csr_we    <= 1'b1;
      csr_wdata <= log2;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One random item. Offsets and drop lengths mostly stay within the capacity
   // so that peeks and drops hit stored bytes; a few use the whole field.
   task automatic send_random(input int unsigned span, input int unsigned write_pct);
      logic [TYPE_W-1:0]  kind;
      logic [COUNT_W-1:0] cnt;
      int unsigned        r;
      r = $urandom_range(0, 99);
      if (r < write_pct) begin
         kind = REQ_WRITE;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40)      kind = REQ_READ;
         else if (r < 70) kind = REQ_PEEK;
         else if (r < 93) kind = REQ_DROP;
         else if (r < 96) kind = REQ_CLEAR;
         else             kind = TYPE_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      end
      r = $urandom_range(0, 99);
      if (kind == REQ_DROP) begin
         if (r < 60)      cnt = COUNT_W'($urandom_range(0, 2));
         else if (r < 90) cnt = COUNT_W'($urandom_range(0, span / 2));
         else             cnt = COUNT_W'($urandom_range(0, 2047));
      end else begin
         if (r < 20)      cnt = COUNT_W'($urandom_range(0, 3));
         else if (r < 95) cnt = COUNT_W'($urandom_range(0, span));
         else             cnt = COUNT_W'($urandom_range(0, 2047));
      end
      send_item(kind, DATA_W'($urandom_range(0, 255)), cnt);
   endtask

   // Receiver: alternate runs of taking and stalling. Stalls are mostly short with
   // an occasional long one; some taking runs last long enough to stream freely.
   initial begin
      bit          taking;
      int unsigned run;
      taking = 1'b1;
      run    = 0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (run != 0) begin
            run--;
         end else begin
            taking = !taking;
            if (taking)
               run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
            else
               run = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(0, 3);
            rsp_ch.ready <= taking;
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("byte_ring_buffer_fifo_core regression: fail");
      $finish;
   end

   initial begin
      int unsigned span;
      int unsigned k;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_WRITE;
      req_ch.write_data <= '0;
      req_ch.count      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset capacity, empty and one-off boundaries, every request code.
      send_item(REQ_READ, 8'h11, 11'd0);       // read when empty: refused
      send_item(REQ_PEEK, 8'h22, 11'd0);       // peek when empty: refused
      send_item(REQ_DROP, 8'h33, 11'd0);       // drop nothing: accepted
      send_item(REQ_DROP, 8'h44, 11'd1);       // drop beyond stored: refused
      send_item(REQ_WRITE, 8'h00, 11'd0);
      send_item(REQ_WRITE, 8'hFF, 11'd2047);
      send_item(REQ_WRITE, 8'hA5, 11'd0);
      send_item(REQ_PEEK, 8'h00, 11'd0);       // head byte
      send_item(REQ_PEEK, 8'h00, 11'd2);       // last stored byte
      send_item(REQ_PEEK, 8'h00, 11'd3);       // offset equal to used: refused
      send_item(REQ_PEEK, 8'h00, 11'd2047);    // largest offset: refused
      send_item(REQ_PEEK, 8'h00, 11'd1024);
      send_item(REQ_DROP, 8'h00, 11'd2047);    // largest drop: refused
      send_item(REQ_READ, 8'h00, 11'd0);
      send_item(REQ_DROP, 8'h00, 11'd2);       // drop exactly what is stored
      send_item(REQ_WRITE, 8'h5A, 11'd0);
      send_item(REQ_CLEAR, 8'h00, 11'd0);
      send_item(REQ_READ, 8'h00, 11'd0);       // empty again after clear
      send_item(REQ_SPARE_LO, 8'hFF, 11'd2047);
      send_item(REQ_SPARE_LO + 3'd1, 8'h00, 11'd0);
      send_item(REQ_SPARE_HI, 8'hFF, 11'd1);
      send_item(REQ_WRITE, 8'h3C, 11'd0);
      send_item(REQ_WRITE, 8'hC3, 11'd0);
      send_item(REQ_DROP, 8'h00, 11'd1);
      send_item(REQ_READ, 8'h00, 11'd0);

      // Random phases, one capacity setting each. Each phase starts idle, so the
      // capacity write lands on a quiet block and usually on a non-empty queue.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_all_answered();
         write_capacity(LOG_W'(phase_log2[p]));
         k    = (phase_log2[p] == 0) ? 1 : phase_log2[p];
         span = (k >= 10) ? STORE_DEPTH : (1 << k);
         gaps_on = ($urandom_range(0, 3) != 0);
         // with a clamped capacity, fill the whole store to the brim and push past it
         if ((1 << phase_log2[p]) > STORE_DEPTH)
            repeat (span + 6) send_item(REQ_WRITE, DATA_W'($urandom_range(0, 255)),
                                        COUNT_W'($urandom_range(0, 2047)));
         for (int i = 0; i < phase_len[p]; i++) begin
            // pause mid-phase on odd phases until the pipeline has drained
            if (p % 2 == 1 && i == phase_len[p] / 2)
               wait_all_answered();
            send_random(span, phase_wpct[p]);
         end
      end

      wait_all_answered();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("byte_ring_buffer_fifo_core regression: pass");
      else
         $display("byte_ring_buffer_fifo_core regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/brbf_pkg.sv
hw/rtl/brbf_channels.sv
hw/rtl/brbf_mem.sv
hw/rtl/brbf_ctrl.sv
hw/rtl/byte_ring_buffer_fifo_core.sv
tb/brbf_checker.sv
tb/testbench.sv
